### rtl/salc_pkg.sv
package salc_pkg;

    localparam int AGE_W = 4;
    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    localparam logic [1:0] MODE_PLAIN     = 2'd0;
    localparam logic [1:0] MODE_NO_WALLOC = 2'd1;
    localparam logic [1:0] MODE_PF_ALWAYS = 2'd2;
    localparam logic [1:0] MODE_PF_MISS   = 2'd3;

    localparam logic [1:0] CFG_WAYS_LOG2   = 2'd0;
    localparam logic [1:0] CFG_POLICY_MODE = 2'd1;

    typedef struct packed {
        logic [31:0] byte_address;
        logic        is_store;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [31:0] hit_count;
        logic [31:0] access_count;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_WRITE
    } t_state;

    typedef enum logic [1:0] {
        K_NONE,
        K_HIT,
        K_FILL,
        K_REPL
    } t_kind;

    typedef struct packed {
        logic capture;
        logic rd;
        logic eval;
        logic wr;
        logic pass;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic demand_hit;
    } t_status;

endpackage

### rtl/salc_ctrl.sv
module salc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_mode,
    input  salc_pkg::t_status i_status,
    output salc_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    salc_pkg::t_state r_state, n_state;
    logic r_pass, n_pass;
    logic prefetch;

    assign prefetch = (i_mode == salc_pkg::MODE_PF_ALWAYS) ||
                      ((i_mode == salc_pkg::MODE_PF_MISS) && !i_status.demand_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= salc_pkg::S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        case (r_state)
            salc_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = salc_pkg::S_READ;
                    n_pass  = 1'b0;
                end
            end
            salc_pkg::S_READ:  n_state = salc_pkg::S_EVAL;
            salc_pkg::S_EVAL:  n_state = salc_pkg::S_WRITE;
            salc_pkg::S_WRITE: begin
                if (!r_pass && prefetch) begin
                    n_state = salc_pkg::S_READ;
                    n_pass  = 1'b1;
                end else begin
                    n_state = salc_pkg::S_IDLE;
                end
            end
            default: n_state = salc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.pass = r_pass;
        o_busy     = 1'b1;
        case (r_state)
            salc_pkg::S_IDLE: begin
                o_busy        = 1'b0;
                o_cmd.capture = i_start;
            end
            salc_pkg::S_READ: o_cmd.rd = 1'b1;
            salc_pkg::S_EVAL: o_cmd.eval = 1'b1;
            salc_pkg::S_WRITE: begin
                o_cmd.wr     = 1'b1;
                o_cmd.report = !r_pass;
            end
            default: o_busy = 1'b1;
        endcase
    end

endmodule

### rtl/salc_dp.sv
module salc_dp #(
    parameter int TOTAL_LINES  = 512,
    parameter int LINE_BYTES   = 32,
    parameter int MAX_WAYS     = 16,
    parameter int ADDRESS_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  salc_pkg::t_cmd    i_cmd,
    input  salc_pkg::t_in     i_data,
    input  logic [2:0]        i_wl,
    input  logic [1:0]        i_mode,
    input  logic              i_geo_clr,
    output salc_pkg::t_status o_status,
    output salc_pkg::t_out    o_result,
    output logic              o_valid
);

    localparam int OB    = $clog2(LINE_BYTES);
    localparam int LT    = $clog2(TOTAL_LINES);
    localparam int BLKB  = ADDRESS_BITS - OB;
    localparam int WLMAX = $clog2(MAX_WAYS + 1) - 1;
    localparam int ROWW  = 1 << WLMAX;
    localparam int ROWS  = TOTAL_LINES >> WLMAX;
    localparam int RAW   = $clog2(ROWS);
    localparam int TAGW  = BLKB - (LT - WLMAX);
    localparam int AW    = salc_pkg::AGE_W;
    localparam int ENTW  = TAGW + AW + 1;

    logic [ADDRESS_BITS-1:0] addr;
    logic [BLKB-1:0]         r_block, r_cur, cur;
    logic                    r_store, r_alloc;
    logic [LT-1:0]           base;
    logic [RAW-1:0]          r_rowaddr;
    logic [WLMAX-1:0]        r_grp, himask;
    logic [ROWW*ENTW-1:0]    mem [ROWS];
    logic [ROWW*ENTW-1:0]    r_rdata, n_row;
    logic [ROWS-1:0]         r_rowv;
    logic                    r_rv;
    logic [BLKB-1:0]         tagfull;
    logic [TAGW-1:0]         tag;
    logic [ROWW-1:0]         ent_v, inset;
    logic [AW-1:0]           ent_age [ROWW];
    logic [TAGW-1:0]         ent_tag [ROWW];
    logic [AW-1:0]           top_age;
    logic                    hit, has_inv, has_old;
    logic [WLMAX-1:0]        hit_w, inv_w, old_w, sel_w;
    salc_pkg::t_kind         kind, r_kind;
    logic [WLMAX-1:0]        r_way;
    logic [AW-1:0]           r_old;
    logic                    r_hit, we;
    logic [31:0]             r_hits, r_accs;
    logic                    r_res_hit, r_strobe;

    assign addr = ADDRESS_BITS'(i_data.byte_address);
    assign cur  = i_cmd.pass ? r_block + BLKB'(1) : r_block;
    assign base = cur[LT-1:0] << i_wl;
    assign himask = ~WLMAX'((1 << i_wl) - 1);
    assign top_age = AW'((1 << i_wl) - 1);

    always_comb begin
        tagfull = r_cur >> (LT - int'(i_wl));
        tag     = TAGW'(tagfull);
    end

    always_comb begin
        for (int j = 0; j < ROWW; j++) begin
            ent_v[j]   = r_rv & r_rdata[j*ENTW + ENTW - 1];
            ent_age[j] = r_rv ? r_rdata[j*ENTW + TAGW +: AW] : '0;
            ent_tag[j] = r_rdata[j*ENTW +: TAGW];
            inset[j]   = ((WLMAX'(j) & himask) == r_grp);
        end
    end

    always_comb begin
        hit     = 1'b0;
        has_inv = 1'b0;
        has_old = 1'b0;
        hit_w   = '0;
        inv_w   = '0;
        old_w   = '0;
        for (int j = ROWW - 1; j >= 0; j--) begin
            if (inset[j] && ent_v[j] && ent_tag[j] == tag) begin
                hit   = 1'b1;
                hit_w = WLMAX'(j);
            end
            if (inset[j] && !ent_v[j]) begin
                has_inv = 1'b1;
                inv_w   = WLMAX'(j);
            end
            if (inset[j] && ent_age[j] == top_age) begin
                has_old = 1'b1;
                old_w   = WLMAX'(j);
            end
        end
        if (hit) begin
            kind  = salc_pkg::K_HIT;
            sel_w = hit_w;
        end else if (!r_alloc) begin
            kind  = salc_pkg::K_NONE;
            sel_w = '0;
        end else if (has_inv) begin
            kind  = salc_pkg::K_FILL;
            sel_w = inv_w;
        end else begin
            kind  = salc_pkg::K_REPL;
            sel_w = has_old ? old_w : r_grp;
        end
    end

    always_comb begin
        n_row = r_rdata;
        for (int j = 0; j < ROWW; j++) begin
            logic          nv;
            logic [AW-1:0] na;
            logic [TAGW-1:0] nt;
            nv = ent_v[j];
            na = ent_age[j];
            nt = ent_tag[j];
            if (inset[j]) begin
                case (r_kind)
                    salc_pkg::K_HIT, salc_pkg::K_REPL: begin
                        if (WLMAX'(j) == r_way) begin
                            na = '0;
                            if (r_kind == salc_pkg::K_REPL) nt = tag;
                        end else if (ent_v[j] && ent_age[j] < r_old) begin
                            na = ent_age[j] + AW'(1);
                        end
                    end
                    salc_pkg::K_FILL: begin
                        if (WLMAX'(j) == r_way) begin
                            nv = 1'b1;
                            na = '0;
                            nt = tag;
                        end else if (ent_v[j] && ent_age[j] != salc_pkg::AGE_MAX) begin
                            na = ent_age[j] + AW'(1);
                        end
                    end
                    default: nv = ent_v[j];
                endcase
            end
            n_row[j*ENTW +: ENTW] = {nv, na, nt};
        end
    end

    assign we = i_cmd.wr && (r_kind != salc_pkg::K_NONE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rdata <= mem[base[LT-1:WLMAX]];
        if (we) mem[r_rowaddr] <= n_row;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_block <= addr[ADDRESS_BITS-1:OB];
            r_store <= i_data.is_store;
        end
        if (i_cmd.rd) begin
            r_cur     <= cur;
            r_alloc   <= i_cmd.pass || !(i_mode == salc_pkg::MODE_NO_WALLOC && r_store);
            r_rowaddr <= base[LT-1:WLMAX];
            r_grp     <= base[WLMAX-1:0];
            r_rv      <= r_rowv[base[LT-1:WLMAX]];
        end
        if (i_cmd.eval) begin
            r_kind <= kind;
            r_way  <= sel_w;
            r_old  <= ent_age[sel_w];
            r_hit  <= hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rowv    <= '0;
            r_hits    <= '0;
            r_accs    <= '0;
            r_res_hit <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            if (i_geo_clr) r_rowv <= '0;
            else if (we) r_rowv[r_rowaddr] <= 1'b1;
            r_strobe <= i_cmd.report;
            if (i_cmd.report) begin
                r_res_hit <= r_hit;
                if (r_accs != '1) r_accs <= r_accs + 32'd1;
                if (r_hit && r_hits != '1) r_hits <= r_hits + 32'd1;
            end
        end
    end

    assign o_status.demand_hit = r_hit;
    assign o_result.hit          = r_res_hit;
    assign o_result.hit_count    = r_hits;
    assign o_result.access_count = r_accs;
    assign o_valid = r_strobe;

endmodule

### rtl/set_assoc_lru_cache_model.sv
// channel   direction  signals                                    transaction when
// access    in         i_start, o_busy, i_data                    i_start & !o_busy
// result    out        o_valid, o_result                          o_valid, one cycle
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_index/data i_cfg_valid & o_cfg_ready
//
// each set lookup is a row read, an evaluate cycle and a row write of the set memory
// an access is one set lookup, two when a next-line prefetch lookup follows
// the result strobes the cycle after the demand lookup writes back
// synchronous active-low reset clears row valid bits and counters and resets config
// the result side cannot stall; a write to ways_log2 invalidates every row at once
module set_assoc_lru_cache_model #(
    parameter int TOTAL_LINES  = 512,
    parameter int LINE_BYTES   = 32,
    parameter int MAX_WAYS     = 16,
    parameter int ADDRESS_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  salc_pkg::t_in  i_data,
    output logic           o_valid,
    output salc_pkg::t_out o_result,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [2:0]     i_cfg_data
);

    localparam int WLMAX = $clog2(MAX_WAYS + 1) - 1;

    logic [2:0]        r_wl, wl_eff;
    logic [1:0]        r_mode;
    logic              cfg_we, geo_clr;
    salc_pkg::t_cmd    cmd;
    salc_pkg::t_status status;

    assign o_cfg_ready = !o_busy;
    assign cfg_we  = i_cfg_valid & o_cfg_ready;
    assign geo_clr = cfg_we && (i_cfg_index == salc_pkg::CFG_WAYS_LOG2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl   <= 3'd1;
            r_mode <= salc_pkg::MODE_PLAIN;
        end else if (cfg_we) begin
            if (i_cfg_index == salc_pkg::CFG_WAYS_LOG2) r_wl <= i_cfg_data;
            else if (i_cfg_index == salc_pkg::CFG_POLICY_MODE) r_mode <= i_cfg_data[1:0];
        end
    end

    always_comb begin
        if (r_wl == 3'd0) wl_eff = 3'd1;
        else if (r_wl > 3'(WLMAX)) wl_eff = 3'(WLMAX);
        else wl_eff = r_wl;
    end

    salc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_mode   (r_mode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    salc_dp #(
        .TOTAL_LINES  (TOTAL_LINES),
        .LINE_BYTES   (LINE_BYTES),
        .MAX_WAYS     (MAX_WAYS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_data    (i_data),
        .i_wl      (wl_eff),
        .i_mode    (r_mode),
        .i_geo_clr (geo_clr),
        .o_status  (status),
        .o_result  (o_result),
        .o_valid   (o_valid)
    );

endmodule

### verif/tb_set_assoc_lru_cache_model.sv
module tb_set_assoc_lru_cache_model;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CFG_SPARE = 2'd2;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 190;

    typedef enum logic [1:0] {
        OP_ACCESS,
        OP_CONFIG,
        OP_DRAIN
    } t_op_kind;

    typedef struct {
        t_op_kind       kind;
        salc_pkg::t_in  access;
        logic [1:0]     index;
        logic [2:0]     value;
    } t_op;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_start = 1'b0;
    logic           o_busy;
    salc_pkg::t_in  i_data = '0;
    logic           o_valid;
    salc_pkg::t_out o_result;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [1:0]     i_cfg_index = '0;
    logic [2:0]     i_cfg_data = '0;

    set_assoc_lru_cache_model dut (.*);

    // cache shadow state
    bit [26:0]  shadow_tag [512];
    bit         shadow_valid [512];
    bit [3:0]   shadow_age [512];
    bit [31:0]  hit_total;
    bit [31:0]  access_total;
    bit [2:0]   ways_log2_reg = 3'd1;
    bit [1:0]   mode_reg = salc_pkg::MODE_PLAIN;

    t_op            stimulus_ops[$];
    salc_pkg::t_out pending_results[$];
    int    gap_left = 0;
    int    settle_count = 0;
    int    stall_count = 0;
    int    error_count = 0;
    int    since_toggle = 0;
    bit    calm = 1'b0;
    bit    stimulus_ready = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_log2(bit [2:0] wl);
        if (wl < 1) return 1;
        if (wl > 4) return 4;
        return int'(wl);
    endfunction

    function automatic void make_recent(int base, int n, int w);
        bit [3:0] old_age;
        old_age = shadow_age[base + w];
        for (int j = 0; j < n; j++)
            if (j != w && shadow_valid[base + j] && shadow_age[base + j] < old_age)
                shadow_age[base + j]++;
        shadow_age[base + w] = '0;
    endfunction

    function automatic bit lookup_block(bit [26:0] blk, bit allocate);
        int wl;
        int n;
        int sets;
        int base;
        int victim;
        bit [26:0] tag;
        wl = clamp_log2(ways_log2_reg);
        n = 1 << wl;
        sets = 512 >> wl;
        base = (blk % sets) * n;
        tag = 27'(blk / sets);
        for (int i = 0; i < n; i++)
            if (shadow_valid[base + i] && shadow_tag[base + i] == tag) begin
                make_recent(base, n, i);
                return 1'b1;
            end
        if (!allocate) return 1'b0;
        for (int i = 0; i < n; i++)
            if (!shadow_valid[base + i]) begin
                for (int j = 0; j < n; j++)
                    if (shadow_valid[base + j] && shadow_age[base + j] < salc_pkg::AGE_MAX)
                        shadow_age[base + j]++;
                shadow_valid[base + i] = 1'b1;
                shadow_tag[base + i] = tag;
                shadow_age[base + i] = '0;
                return 1'b0;
            end
        victim = 0;
        for (int i = 1; i < n; i++)
            if (shadow_age[base + i] > shadow_age[base + victim]) victim = i;
        make_recent(base, n, victim);
        shadow_tag[base + victim] = tag;
        return 1'b0;
    endfunction

    function automatic void predict_access(salc_pkg::t_in acc);
        bit [26:0] blk;
        bit hit;
        salc_pkg::t_out res;
        blk = acc.byte_address[31:5];
        hit = lookup_block(blk, !(mode_reg == salc_pkg::MODE_NO_WALLOC && acc.is_store));
        if (access_total != '1) access_total++;
        if (hit && hit_total != '1) hit_total++;
        if (mode_reg == salc_pkg::MODE_PF_ALWAYS ||
            (mode_reg == salc_pkg::MODE_PF_MISS && !hit))
            void'(lookup_block(blk + 27'd1, 1'b1));
        res.hit = hit;
        res.hit_count = hit_total;
        res.access_count = access_total;
        pending_results.push_back(res);
    endfunction

    function automatic void apply_config(logic [1:0] index, logic [2:0] value);
        if (index == salc_pkg::CFG_WAYS_LOG2) begin
            ways_log2_reg = value;
            for (int i = 0; i < 512; i++) begin
                shadow_valid[i] = 1'b0;
                shadow_age[i] = '0;
            end
        end else if (index == salc_pkg::CFG_POLICY_MODE) begin
            mode_reg = value[1:0];
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_access(bit [31:0] addr, bit st);
        t_op op;
        op.kind = OP_ACCESS;
        op.access.byte_address = addr;
        op.access.is_store = st;
        stimulus_ops.push_back(op);
    endtask

    task automatic add_config(logic [1:0] index, logic [2:0] value);
        t_op op;
        op.kind = OP_DRAIN;
        stimulus_ops.push_back(op);
        op.kind = OP_CONFIG;
        op.index = index;
        op.value = value;
        stimulus_ops.push_back(op);
    endtask

    task automatic add_drain();
        t_op op;
        op.kind = OP_DRAIN;
        stimulus_ops.push_back(op);
    endtask

    // mostly a few hot sets with a handful of tags so hits and evictions are common
    function automatic bit [31:0] random_address(int sets, int ways);
        int r;
        bit [26:0] blk;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            blk = 27'($urandom_range(0, ways + 3) * sets + $urandom_range(0, 7));
            if ($urandom_range(0, 3) == 0) blk = blk + 27'(sets) * 27'($urandom);
        end else if (r < 85) begin
            blk = 27'($urandom) | 27'h7ffff00;
        end else begin
            return $urandom;
        end
        return {blk, 5'($urandom)};
    endfunction

    task automatic add_random_phase(bit [2:0] wl, bit [1:0] mode);
        int eff;
        add_config(salc_pkg::CFG_WAYS_LOG2, wl);
        add_config(salc_pkg::CFG_POLICY_MODE, {1'b0, mode});
        eff = clamp_log2(wl);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            add_access(random_address(512 >> eff, 1 << eff), 1'($urandom));
            if (i == PHASE_ITEMS / 2) add_drain();
        end
    endtask

    initial begin
        // directed: two ways, 256 sets, set stride 8 KiB
        add_access(32'h0000_0000, 1'b0);
        add_access(32'h0000_001f, 1'b1);
        add_access(32'hffff_ffff, 1'b0);
        add_access(32'h0000_2000, 1'b0);
        add_access(32'h0000_4000, 1'b0);
        add_access(32'h0000_0000, 1'b0);
        add_access(32'h0000_2000, 1'b1);
        add_config(CFG_SPARE, 3'd7);
        add_config(salc_pkg::CFG_POLICY_MODE, {1'b0, salc_pkg::MODE_NO_WALLOC});
        add_access(32'h1234_5660, 1'b1);
        add_access(32'h1234_5660, 1'b0);
        add_access(32'h1234_5660, 1'b1);
        add_access(32'h0000_4000, 1'b1);
        add_config(salc_pkg::CFG_POLICY_MODE, {1'b0, salc_pkg::MODE_PF_ALWAYS});
        add_access(32'hffff_ffe0, 1'b0);
        add_access(32'h0000_0000, 1'b0);
        add_access(32'h0000_0020, 1'b1);
        add_config(salc_pkg::CFG_POLICY_MODE, {1'b0, salc_pkg::MODE_PF_MISS});
        add_access(32'h8000_0000, 1'b0);
        add_access(32'h8000_0020, 1'b0);
        add_access(32'h8000_0000, 1'b0);
        add_config(salc_pkg::CFG_WAYS_LOG2, 3'd0);
        add_access(32'h8000_0000, 1'b0);
        add_access(32'h7fff_ffe0, 1'b1);

        add_random_phase(3'd1, salc_pkg::MODE_PLAIN);
        add_random_phase(3'd4, salc_pkg::MODE_NO_WALLOC);
        add_random_phase(3'd2, salc_pkg::MODE_PF_ALWAYS);
        add_random_phase(3'd3, salc_pkg::MODE_PF_MISS);
        add_random_phase(3'd7, salc_pkg::MODE_PLAIN);
        add_random_phase(3'd0, salc_pkg::MODE_PF_ALWAYS);
        add_random_phase(3'd5, salc_pkg::MODE_NO_WALLOC);
        add_random_phase(3'd4, salc_pkg::MODE_PF_MISS);
        add_random_phase(3'd1, salc_pkg::MODE_NO_WALLOC);
        add_random_phase(3'd3, salc_pkg::MODE_PLAIN);
        add_random_phase(3'd6, salc_pkg::MODE_PF_MISS);
        stimulus_ready = 1'b1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stimulus_ops.size() != 0 || i_start || i_cfg_valid
               || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("set_assoc_lru_cache_model: match");
        end else begin
            $display("set_assoc_lru_cache_model: mismatch");
        end
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        t_op head;
        logic next_start;
        logic next_cfg;
        next_start = i_start;
        next_cfg = i_cfg_valid;
        if (!i_rst_n || !stimulus_ready) begin
            next_start = 1'b0;
            next_cfg = 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                predict_access(i_data);
                next_start = 1'b0;
                gap_left = pick_gap();
                if (++since_toggle == 150) begin
                    since_toggle = 0;
                    calm = ($urandom_range(0, 3) == 0);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_config(i_cfg_index, i_cfg_data);
                next_cfg = 1'b0;
            end
            if (!next_start && !next_cfg) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stimulus_ops.size() > 0) begin
                    head = stimulus_ops[0];
                    case (head.kind)
                        OP_ACCESS: begin
                            void'(stimulus_ops.pop_front());
                            i_data <= head.access;
                            next_start = 1'b1;
                        end
                        OP_CONFIG: begin
                            void'(stimulus_ops.pop_front());
                            i_cfg_index <= head.index;
                            i_cfg_data <= head.value;
                            next_cfg = 1'b1;
                        end
                        default: begin
                            if (pending_results.size() != 0) begin
                                settle_count = 0;
                            end else if (settle_count == DRAIN_CYCLES) begin
                                settle_count = 0;
                                void'(stimulus_ops.pop_front());
                            end else begin
                                settle_count++;
                            end
                        end
                    endcase
                end
            end
        end
        i_start <= next_start;
        i_cfg_valid <= next_cfg;
    end

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("error: %s got %0h expected %0h at %0t", field, got, want, $realtime);
        error_count++;
    endtask

    // monitor and watchdog
    always @(posedge i_clk) begin
        salc_pkg::t_out want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected transaction", o_result.access_count, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.hit !== want.hit)
                        report_mismatch("hit", 32'(o_result.hit), 32'(want.hit));
                    if (o_result.hit_count !== want.hit_count)
                        report_mismatch("hit_count", o_result.hit_count, want.hit_count);
                    if (o_result.access_count !== want.access_count)
                        report_mismatch("access_count", o_result.access_count,
                                        want.access_count);
                end
            end
            if (o_valid || (i_start && !o_busy) || (i_cfg_valid && o_cfg_ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("set_assoc_lru_cache_model: mismatch");
                $finish;
            end
        end
    end

endmodule
